// ===== rtl/sws_pkg.sv =====
// ----------------------------------------------------------------------------
// sws_pkg: shared types and codes of the stop-and-wait sender
// Transaction payload structs, event, packet and action codes, phase codes, error codes, config indices.
// ----------------------------------------------------------------------------
package sws_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 64000;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_SESSION_TAG    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSFER_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT    = 2'd2;

  localparam logic [7:0] RETRY_LIMIT_RST = 8'd5;

  localparam logic [1:0] FUNC_START   = 2'd0;
  localparam logic [1:0] FUNC_PACKET  = 2'd1;
  localparam logic [1:0] FUNC_TIMEOUT = 2'd2;
  localparam logic [1:0] FUNC_ABORT   = 2'd3;

  localparam logic [2:0] KIND_ACCEPT   = 3'd0;
  localparam logic [2:0] KIND_CONN_REJ = 3'd1;
  localparam logic [2:0] KIND_ACK      = 3'd2;
  localparam logic [2:0] KIND_REJECT   = 3'd3;
  localparam logic [2:0] KIND_RECEIVED = 3'd4;

  localparam logic [1:0] ACT_CONNECT = 2'd0;
  localparam logic [1:0] ACT_DATA    = 2'd1;
  localparam logic [1:0] ACT_DONE    = 2'd2;
  localparam logic [1:0] ACT_ERROR   = 2'd3;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_TIMEOUT  = 3'd1;
  localparam logic [2:0] ERR_REJECTED = 3'd2;
  localparam logic [2:0] ERR_INVALID  = 3'd3;
  localparam logic [2:0] ERR_ABORTED  = 3'd4;
  localparam logic [2:0] ERR_REFUSED  = 3'd5;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_CONNECT = 3'd1;
  localparam logic [2:0] PH_SEND    = 3'd2;
  localparam logic [2:0] PH_AWAIT   = 3'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  rx_kind;
    logic        rx_length_ok;
    logic [63:0] rx_session;
    logic [63:0] rx_number;
  } sws_in_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] seq_number;
    logic [31:0] payload_offset;
    logic [15:0] payload_length;
    logic [2:0]  error_code;
  } sws_out_t;

endpackage

// ===== rtl/sws_if.sv =====
// ----------------------------------------------------------------------------
// sws_if: valid/ready channels of the stop-and-wait sender
// One interface for event transactions, one for result transactions.
// ----------------------------------------------------------------------------
interface sws_in_if
  import sws_pkg::*;
();
  logic    valid;
  logic    ready;
  sws_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sws_out_if
  import sws_pkg::*;
();
  logic     valid;
  logic     ready;
  sws_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/stop_and_wait_sender.sv =====
// ----------------------------------------------------------------------------
// stop_and_wait_sender: sender side of a stop-and-wait ARQ transfer
// Event register, one pass of session logic, result register.
// ----------------------------------------------------------------------------
// The block takes one event transaction per clock cycle while the result channel
// does not stall it. An accepted event is held in the event register, and the
// session logic writes its outcome into the result register when that register
// can advance; the result register drives the result channel. Backpressure on
// the result channel stalls both stages; events that cause no result wait for
// it as well.
// All session state updates in the single pass between the two registers, so a
// following event always sees the state left by the one before.
module stop_and_wait_sender
  import sws_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  sws_in_if.sink                in_ch,
  sws_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [15:0] MaxLen = MAX_PAYLOAD[15:0];

  logic [63:0] session_tag_r;
  logic [31:0] transfer_bytes_r;
  logic [7:0]  retry_limit_r;

  logic        stg_valid_r;
  sws_in_t     stg_data_r;
  logic        out_valid_r;
  sws_out_t    out_data_r;

  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  retry_count_r, retry_count_nxt;
  logic [63:0] current_number_r, current_number_nxt;
  logic [31:0] bytes_left_r, bytes_left_nxt;
  logic [31:0] next_offset_r, next_offset_nxt;
  logic [15:0] current_length_r, current_length_nxt;

  logic        adv;
  logic        res_valid;
  sws_out_t    res;
  logic        good;
  logic        num_eq;
  logic        num_lt;
  logic [31:0] left_after;
  logic [31:0] left_sel;
  logic [15:0] len_sel;

  assign adv          = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !stg_valid_r || adv;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  assign good   = stg_data_r.rx_length_ok && (stg_data_r.rx_session == session_tag_r);
  assign num_eq = stg_data_r.rx_number == current_number_r;
  assign num_lt = stg_data_r.rx_number < current_number_r;
  assign left_after = bytes_left_r - {16'd0, current_length_r};

  always_comb begin
    left_sel = (phase_r == PH_CONNECT) ? bytes_left_r : left_after;
    len_sel  = (left_sel < {16'd0, MaxLen}) ? left_sel[15:0] : MaxLen;
  end

  always_comb begin
    phase_nxt          = phase_r;
    retry_count_nxt    = retry_count_r;
    current_number_nxt = current_number_r;
    bytes_left_nxt     = bytes_left_r;
    next_offset_nxt    = next_offset_r;
    current_length_nxt = current_length_r;
    res_valid          = 1'b0;
    res                = '0;

    if (stg_valid_r && adv) begin
      if (stg_data_r.func == FUNC_START) begin
        if (phase_r == PH_IDLE) begin
          phase_nxt          = PH_CONNECT;
          retry_count_nxt    = '0;
          current_number_nxt = '0;
          bytes_left_nxt     = transfer_bytes_r;
          next_offset_nxt    = '0;
          current_length_nxt = '0;
          res_valid          = 1'b1;
          res.action         = ACT_CONNECT;
        end
      end else if (phase_r != PH_IDLE) begin
        priority if (stg_data_r.func == FUNC_ABORT) begin
          phase_nxt      = PH_IDLE;
          res_valid      = 1'b1;
          res.action     = ACT_ERROR;
          res.error_code = ERR_ABORTED;
        end else if (stg_data_r.func == FUNC_TIMEOUT) begin
          res_valid = 1'b1;
          if (phase_r == PH_AWAIT || retry_count_r >= retry_limit_r) begin
            phase_nxt      = PH_IDLE;
            res.action     = ACT_ERROR;
            res.error_code = ERR_TIMEOUT;
          end else begin
            retry_count_nxt = retry_count_r + 8'd1;
            if (phase_r == PH_CONNECT) begin
              res.action = ACT_CONNECT;
            end else begin
              res.action         = ACT_DATA;
              res.seq_number     = current_number_r;
              res.payload_offset = next_offset_r;
              res.payload_length = current_length_r;
            end
          end
        end else begin
          res.action     = ACT_ERROR;
          res.error_code = ERR_INVALID;
          unique case (phase_r)
            PH_CONNECT: begin
              if (good && stg_data_r.rx_kind == KIND_ACCEPT) begin
                retry_count_nxt = '0;
                if (bytes_left_r == '0) begin
                  phase_nxt = PH_AWAIT;
                end else begin
                  phase_nxt          = PH_SEND;
                  current_length_nxt = len_sel;
                  res_valid          = 1'b1;
                  res.action         = ACT_DATA;
                  res.error_code     = ERR_NONE;
                  res.seq_number     = current_number_r;
                  res.payload_offset = next_offset_r;
                  res.payload_length = len_sel;
                end
              end else begin
                phase_nxt = PH_IDLE;
                res_valid = 1'b1;
                if (good && stg_data_r.rx_kind == KIND_CONN_REJ) begin
                  res.error_code = ERR_REFUSED;
                end
              end
            end
            PH_SEND: begin
              priority if (good && stg_data_r.rx_kind == KIND_ACK && num_eq) begin
                current_number_nxt = current_number_r + 64'd1;
                next_offset_nxt    = next_offset_r + {16'd0, current_length_r};
                bytes_left_nxt     = left_after;
                retry_count_nxt    = '0;
                if (left_after == '0) begin
                  phase_nxt = PH_AWAIT;
                end else begin
                  current_length_nxt = len_sel;
                  res_valid          = 1'b1;
                  res.action         = ACT_DATA;
                  res.error_code     = ERR_NONE;
                  res.seq_number     = current_number_r + 64'd1;
                  res.payload_offset = next_offset_r + {16'd0, current_length_r};
                  res.payload_length = len_sel;
                end
              end else if (good && stg_data_r.rx_kind == KIND_REJECT && num_eq) begin
                phase_nxt      = PH_IDLE;
                res_valid      = 1'b1;
                res.error_code = ERR_REJECTED;
              end else if (good && ((stg_data_r.rx_kind == KIND_ACK && num_lt) ||
                                    stg_data_r.rx_kind == KIND_ACCEPT)) begin
                res_valid = 1'b0;
              end else begin
                phase_nxt = PH_IDLE;
                res_valid = 1'b1;
              end
            end
            PH_AWAIT: begin
              priority if (good && stg_data_r.rx_kind == KIND_RECEIVED) begin
                phase_nxt      = PH_IDLE;
                res_valid      = 1'b1;
                res.action     = ACT_DONE;
                res.error_code = ERR_NONE;
              end else if (good && (stg_data_r.rx_kind == KIND_ACCEPT ||
                                    stg_data_r.rx_kind == KIND_ACK)) begin
                res_valid = 1'b0;
              end else begin
                phase_nxt = PH_IDLE;
                res_valid = 1'b1;
              end
            end
            default: begin
              phase_nxt = PH_IDLE;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      session_tag_r    <= '0;
      transfer_bytes_r <= '0;
      retry_limit_r    <= RETRY_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SESSION_TAG:    session_tag_r    <= cfg_wdata;
        CFG_TRANSFER_BYTES: transfer_bytes_r <= cfg_wdata[31:0];
        CFG_RETRY_LIMIT:    retry_limit_r    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r      <= 1'b0;
      out_valid_r      <= 1'b0;
      phase_r          <= PH_IDLE;
      retry_count_r    <= '0;
      current_number_r <= '0;
      bytes_left_r     <= '0;
      next_offset_r    <= '0;
      current_length_r <= '0;
    end else begin
      if (in_ch.ready) begin
        stg_valid_r <= in_ch.valid;
      end
      if (adv) begin
        out_valid_r <= res_valid;
      end
      phase_r          <= phase_nxt;
      retry_count_r    <= retry_count_nxt;
      current_number_r <= current_number_nxt;
      bytes_left_r     <= bytes_left_nxt;
      next_offset_r    <= next_offset_nxt;
      current_length_r <= current_length_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready) begin
      stg_data_r <= in_ch.data;
    end
    if (adv) begin
      out_data_r <= res;
    end
  end

endmodule

// ===== rtl/sws_checker.sv =====
// ----------------------------------------------------------------------------
// sws_checker: port-level checks of the stop-and-wait sender
// Result transaction consistency and stall behavior, bound to the top level.
// ----------------------------------------------------------------------------
module sws_checker
  import sws_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input sws_out_t out_data
);

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.action == ACT_ERROR) == (out_data.error_code != ERR_NONE)))
    else $error("error code disagrees with action");

  a_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.action != ACT_DATA) |->
      (out_data.seq_number == '0 && out_data.payload_offset == '0 &&
       out_data.payload_length == '0))
    else $error("packet fields set on a non-data result");

  a_data_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.action == ACT_DATA) |-> (out_data.payload_length != '0))
    else $error("data result with empty payload");

  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    (!$past(in_valid && in_ready, 2) && !$past(out_valid)) |-> !out_valid)
    else $error("result without a preceding event transaction");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result transaction changed");

endmodule

bind stop_and_wait_sender sws_checker u_sws_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
